// ===== sv/mcmp_pkg.sv =====
// Shared types and constants for the MIDI channel message parser.
package mcmp_pkg;

  // Result event kinds
  typedef enum logic [1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_CONTROL  = 2'd2
  } event_kind_t;

  // Special status bytes
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_END    = 8'hF7;
  localparam logic [7:0] REALTIME_MIN = 8'hF8;
  localparam logic [7:0] NO_STATUS    = 8'h00;

  // Status high nibbles
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_CONTROL  = 4'hB;
  localparam logic [3:0] NIB_PROGRAM  = 4'hC;
  localparam logic [3:0] NIB_PRESSURE = 4'hD;
  localparam logic [3:0] NIB_SYSTEM   = 4'hF;

endpackage

// ===== sv/mcmp_if.sv =====
// Valid/ready channel interfaces for received bytes and parsed events.
interface mcmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mcmp_event_if;
  logic                 valid;
  logic                 ready;
  mcmp_pkg::event_kind_t event_kind;
  logic [4:0]           channel_number;
  logic [6:0]           first_value;
  logic [6:0]           second_value;

  modport source (output valid, output event_kind, output channel_number,
                  output first_value, output second_value, input ready);
  modport sink   (input valid, input event_kind, input channel_number,
                  input first_value, input second_value, output ready);
endinterface

// ===== sv/midi_channel_message_parser.sv =====
// MIDI channel message parser with running status: input register, decode, result register.
//
// Usage:
//   in_byte   carries one received MIDI byte per beat (valid/ready).
//   out_event carries one parsed note-on, note-off or control-change
//             event per beat: kind, channel 1..16, first and second value.
//   Real-time bytes are dropped, SysEx data is skipped until F7, and bytes
//   that complete no note or controller message give no event.
// Path: the byte that completes an event is held in the input register;
//   the decode stage then writes the event into the result register,
//   which drives out_event.
// Throughput: one byte per cycle while out_event is taken; the single
//   decode stage with its parser state registers sets this figure.
// Reset (rst_n low, synchronous): parser state clears to no status, no
//   running status, no pending data, not skipping; both stages empty.
// Stall: while a result waits on out_event the input register still takes
//   one more byte; the decode stage then holds until the result is taken.
module midi_channel_message_parser (
  input  logic                clk,
  input  logic                rst_n,
  mcmp_byte_if.sink           in_byte,
  mcmp_event_if.source        out_event
);

  // Input register
  logic       in_valid_r;
  logic [7:0] in_data_r;

  // Parser state
  logic [7:0] cur_status_r,  cur_status_nxt;
  logic [7:0] run_status_r,  run_status_nxt;
  logic       data_cnt_r,    data_cnt_nxt;
  logic [6:0] first_data_r,  first_data_nxt;
  logic       sysex_skip_r,  sysex_skip_nxt;

  // Result register
  logic                  out_valid_r;
  mcmp_pkg::event_kind_t kind_r, kind_nxt;
  logic [4:0]            chan_r, chan_nxt;
  logic [6:0]            val1_r, val1_nxt;
  logic [6:0]            val2_r, val2_nxt;

  logic       advance;
  logic       process;
  logic       emit;
  logic [7:0] cs;
  logic       cnt_eff;
  logic       need_two;
  logic [6:0] d1;
  logic [6:0] d2;
  logic       have_msg;

  // Advance the decode stage when the result register is free or drains
  assign advance = !out_valid_r || out_event.ready;
  assign process = in_valid_r && advance;
  assign in_byte.ready = !in_valid_r || advance;

  // Decode one byte and update parser state
  always_comb begin
    cur_status_nxt = cur_status_r;
    run_status_nxt = run_status_r;
    data_cnt_nxt   = data_cnt_r;
    first_data_nxt = first_data_r;
    sysex_skip_nxt = sysex_skip_r;
    emit           = 1'b0;
    kind_nxt       = mcmp_pkg::KIND_NOTE_ON;
    cs             = cur_status_r;
    cnt_eff        = data_cnt_r;
    need_two       = 1'b1;
    d1             = in_data_r[6:0];
    d2             = 7'd0;
    have_msg       = 1'b0;

    if (in_data_r[7]) begin
      // Status byte; drop real-time bytes
      if (in_data_r < mcmp_pkg::REALTIME_MIN) begin
        cur_status_nxt = in_data_r;
        data_cnt_nxt   = 1'b0;
        if (in_data_r[7:4] == mcmp_pkg::NIB_SYSTEM) begin
          if (in_data_r == mcmp_pkg::SYSEX_START) begin
            sysex_skip_nxt = 1'b1;
          end else if (in_data_r == mcmp_pkg::SYSEX_END) begin
            sysex_skip_nxt = 1'b0;
          end
        end else begin
          run_status_nxt = in_data_r;
        end
      end
    end else begin
      // Take up running status when no current status
      if (cur_status_r == mcmp_pkg::NO_STATUS &&
          run_status_r != mcmp_pkg::NO_STATUS) begin
        cs      = run_status_r;
        cnt_eff = 1'b0;
      end
      cur_status_nxt = cs;
      data_cnt_nxt   = cnt_eff;
      need_two = !(cs[7:4] == mcmp_pkg::NIB_PROGRAM ||
                   cs[7:4] == mcmp_pkg::NIB_PRESSURE);

      if (!sysex_skip_r && cs != mcmp_pkg::NO_STATUS) begin
        if (!cnt_eff) begin
          if (need_two) begin
            first_data_nxt = in_data_r[6:0];
            data_cnt_nxt   = 1'b1;
          end else begin
            d1       = in_data_r[6:0];
            d2       = 7'd0;
            have_msg = 1'b1;
          end
        end else begin
          d1           = first_data_r;
          d2           = need_two ? in_data_r[6:0] : 7'd0;
          data_cnt_nxt = 1'b0;
          have_msg     = 1'b1;
        end
      end

      // Classify the completed message
      if (have_msg) begin
        case (cs[7:4])
          mcmp_pkg::NIB_NOTE_ON: begin
            kind_nxt = (d2 == 7'd0) ? mcmp_pkg::KIND_NOTE_OFF : mcmp_pkg::KIND_NOTE_ON;
            emit     = 1'b1;
          end
          mcmp_pkg::NIB_NOTE_OFF: begin
            kind_nxt = mcmp_pkg::KIND_NOTE_OFF;
            emit     = 1'b1;
          end
          mcmp_pkg::NIB_CONTROL: begin
            kind_nxt = mcmp_pkg::KIND_CONTROL;
            emit     = 1'b1;
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
    end

    chan_nxt = {1'b0, cs[3:0]} + 5'd1;
    val1_nxt = d1;
    val2_nxt = d2;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      cur_status_r <= mcmp_pkg::NO_STATUS;
      run_status_r <= mcmp_pkg::NO_STATUS;
      data_cnt_r   <= 1'b0;
      first_data_r <= 7'd0;
      sysex_skip_r <= 1'b0;
    end else begin
      // Hold the input register until the decode stage takes it
      if (in_byte.ready) begin
        in_valid_r <= in_byte.valid;
      end
      if (advance) begin
        out_valid_r <= process && emit;
      end
      if (process) begin
        cur_status_r <= cur_status_nxt;
        run_status_r <= run_status_nxt;
        data_cnt_r   <= data_cnt_nxt;
        first_data_r <= first_data_nxt;
        sysex_skip_r <= sysex_skip_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_byte.ready && in_byte.valid) begin
      in_data_r <= in_byte.rx_byte;
    end
    if (process && emit) begin
      kind_r <= kind_nxt;
      chan_r <= chan_nxt;
      val1_r <= val1_nxt;
      val2_r <= val2_nxt;
    end
  end

  assign out_event.valid          = out_valid_r;
  assign out_event.event_kind     = kind_r;
  assign out_event.channel_number = chan_r;
  assign out_event.first_value    = val1_r;
  assign out_event.second_value   = val2_r;

endmodule

// ===== dv/midi_event_scoreboard_pkg.sv =====
// Event scoreboard: parser state tracking and in-order event comparison.
`timescale 1ns / 1ps
package midi_event_scoreboard_pkg;

  typedef struct packed {
    mcmp_pkg::event_kind_t kind;
    logic [4:0]            channel;
    logic [6:0]            first;
    logic [6:0]            second;
  } midi_event_t;

  class midi_event_scoreboard;
    logic [7:0]  cur_status;
    logic [7:0]  run_status;
    bit          have_first;
    logic [6:0]  held_first;
    bit          in_sysex;
    midi_event_t expected_events[$];
    int unsigned failures;

    function new();
      cur_status = mcmp_pkg::NO_STATUS;
      run_status = mcmp_pkg::NO_STATUS;
      have_first = 1'b0;
      held_first = '0;
      in_sysex   = 1'b0;
      failures   = 0;
    endfunction

    // Advance the parser state on one accepted byte; queue the event it completes.
    function void take_byte(logic [7:0] b);
      logic [3:0]            nib;
      bit                    single;
      logic [6:0]            d1;
      logic [6:0]            d2;
      mcmp_pkg::event_kind_t kind;
      midi_event_t           ev;

      if (b[7]) begin
        if (b >= mcmp_pkg::REALTIME_MIN) return;
        cur_status = b;
        have_first = 1'b0;
        if (b[7:4] == mcmp_pkg::NIB_SYSTEM) begin
          if (b == mcmp_pkg::SYSEX_START) in_sysex = 1'b1;
          else if (b == mcmp_pkg::SYSEX_END) in_sysex = 1'b0;
        end else begin
          run_status = b;
        end
        return;
      end

      // Pick up the running status when no current status is held
      if (cur_status == mcmp_pkg::NO_STATUS && run_status != mcmp_pkg::NO_STATUS) begin
        cur_status = run_status;
        have_first = 1'b0;
      end
      if (in_sysex || cur_status == mcmp_pkg::NO_STATUS) return;

      nib    = cur_status[7:4];
      single = (nib == mcmp_pkg::NIB_PROGRAM) || (nib == mcmp_pkg::NIB_PRESSURE);
      if (!have_first) begin
        if (!single) begin
          held_first = b[6:0];
          have_first = 1'b1;
          return;
        end
        d1 = b[6:0];
        d2 = '0;
      end else begin
        d1 = held_first;
        d2 = single ? 7'd0 : b[6:0];
        have_first = 1'b0;
      end

      case (nib)
        mcmp_pkg::NIB_NOTE_ON:
          kind = (d2 == 7'd0) ? mcmp_pkg::KIND_NOTE_OFF : mcmp_pkg::KIND_NOTE_ON;
        mcmp_pkg::NIB_NOTE_OFF: kind = mcmp_pkg::KIND_NOTE_OFF;
        mcmp_pkg::NIB_CONTROL:  kind = mcmp_pkg::KIND_CONTROL;
        default:                return;
      endcase

      ev.kind    = kind;
      ev.channel = {1'b0, cur_status[3:0]} + 5'd1;
      ev.first   = d1;
      ev.second  = d2;
      expected_events.push_back(ev);
    endfunction

    // Compare one event beat against the oldest expectation.
    function void check_event(midi_event_t got);
      midi_event_t exp_ev;

      if (expected_events.size() == 0) begin
        $display("%0t: event expected none actual kind=%0d ch=%0d v1=%0d v2=%0d", $time,
                 got.kind, got.channel, got.first, got.second);
        failures++;
        return;
      end
      exp_ev = expected_events.pop_front();
      if (got.kind !== exp_ev.kind) begin
        $display("%0t: event_kind expected %0d actual %0d", $time, exp_ev.kind, got.kind);
        failures++;
      end
      if (got.channel !== exp_ev.channel) begin
        $display("%0t: channel_number expected %0d actual %0d", $time,
                 exp_ev.channel, got.channel);
        failures++;
      end
      if (got.first !== exp_ev.first) begin
        $display("%0t: first_value expected %0d actual %0d", $time, exp_ev.first, got.first);
        failures++;
      end
      if (got.second !== exp_ev.second) begin
        $display("%0t: second_value expected %0d actual %0d", $time,
                 exp_ev.second, got.second);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_events.size();
    endfunction
  endclass

endpackage

// ===== dv/midi_channel_message_parser_test.sv =====
// Top-level testbench for the MIDI channel message parser.
`timescale 1ns / 1ps
module midi_channel_message_parser_test;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_BYTES = 475;
  localparam logic [7:0] DIRECTED [27] = '{
    8'h00,                      // data before any status
    8'h90, 8'h3C, 8'h40,        // note on, channel 1
    8'h3C, 8'h00,               // running status, zero velocity
    8'hF8,                      // real-time in the stream
    8'h8F, 8'h7F, 8'hFF, 8'h7F, // note off, channel 16, real-time mid-message
    8'hB5, 8'h00, 8'h7F,        // control change
    8'hC3, 8'h12,               // program change, no event
    8'hF0, 8'h92, 8'h10, 8'h20, 8'hF7, // channel status inside SysEx
    8'hF1, 8'h05, 8'h06,        // system common swallows data
    8'h9A, 8'h7F, 8'h01         // note on, channel 11
  };

  logic clk;
  logic rst_n;
  int unsigned cycle_count;
  int unsigned sent_bytes;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;

  midi_event_scoreboard_pkg::midi_event_scoreboard parser_sb = new();

  mcmp_byte_if  in_byte_if();
  mcmp_event_if out_event_if();

  midi_channel_message_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_byte_if),
    .out_event(out_event_if)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort on runaway
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sample both channels; score the event before noting the byte
  always @(posedge clk) begin
    midi_event_scoreboard_pkg::midi_event_t got;
    if (rst_n) begin
      if (out_event_if.valid && out_event_if.ready) begin
        got.kind    = out_event_if.event_kind;
        got.channel = out_event_if.channel_number;
        got.first   = out_event_if.first_value;
        got.second  = out_event_if.second_value;
        parser_sb.check_event(got);
      end
      if (in_byte_if.valid && in_byte_if.ready) parser_sb.take_byte(in_byte_if.rx_byte);
    end
  end

  // Drive out_event ready: long hold-off first, then random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_event_if.ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_event_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one byte, idling first at random, and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_byte_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_byte_if.valid   <= 1'b1;
    in_byte_if.rx_byte <= b;
    do @(posedge clk); while (!in_byte_if.ready);
    if (b < mcmp_pkg::REALTIME_MIN) sent_bytes++;
  endtask

  // Send a byte, sometimes preceded by a real-time byte
  task automatic send_live(input logic [7:0] b);
    if ($urandom_range(99) < 6) send_byte(8'($urandom_range(8'hFF, mcmp_pkg::REALTIME_MIN)));
    send_byte(b);
  endtask

  function automatic logic [7:0] data_byte();
    if ($urandom_range(9) == 0) return 8'h00;
    return {1'b0, 7'($urandom_range(127))};
  endfunction

  // One traffic phase: mostly well-formed messages, some SysEx, system common and noise
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned hold);
    int unsigned start;
    int unsigned pick;
    int unsigned need;
    logic [3:0]  nib;

    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    hold_cycles    = hold;
    start          = sent_bytes;
    while (sent_bytes - start < PHASE_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        nib  = 4'($urandom_range(4'hE, mcmp_pkg::NIB_NOTE_OFF));
        need = (nib == mcmp_pkg::NIB_PROGRAM || nib == mcmp_pkg::NIB_PRESSURE) ? 1 : 2;
        if ($urandom_range(3) != 0) send_live({nib, 4'($urandom_range(15))});
        repeat ($urandom_range(3, 1) * need) send_live(data_byte());
      end else if (pick < 74) begin
        send_live(mcmp_pkg::SYSEX_START);
        repeat ($urandom_range(4)) send_live(data_byte());
        if ($urandom_range(3) == 0) send_live(8'($urandom_range(8'hEF, 8'h80)));
        repeat ($urandom_range(2)) send_live(data_byte());
        if ($urandom_range(9) != 0) send_live(mcmp_pkg::SYSEX_END);
      end else if (pick < 82) begin
        send_live(8'($urandom_range(8'hF6, 8'hF1)));
        repeat ($urandom_range(3)) send_live(data_byte());
      end else begin
        send_live(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    in_byte_if.valid     = 1'b0;
    in_byte_if.rx_byte   = 8'h00;
    out_event_if.ready   = 1'b0;
    cycle_count          = 0;
    sent_bytes           = 0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    hold_cycles          = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed edge cases at full rate
    foreach (DIRECTED[i]) send_byte(DIRECTED[i]);

    // Random phases; the first starts with a long receiver hold-off
    run_phase(0, 0, 400);
    run_phase(71, 0, 0);
    run_phase(0, 71, 0);
    run_phase(35, 35, 0);

    @(negedge clk);
    in_byte_if.valid <= 1'b0;

    // Drain outstanding events, then watch for strays
    while (parser_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (parser_sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
